// ===== rtl/circle_from_points_defines.svh =====
// assertion macros for the circle from points rtl
`ifndef CIRCLE_FROM_POINTS_DEFINES_SVH
`define CIRCLE_FROM_POINTS_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies outcome in the next
`define CFP_ASSERT_NEXT(label, pre, post, msg) \
   `CFP_ASSERT(label, pre |=> post, msg)

`endif

// ===== rtl/cfp_pkg.sv =====
// types, widths and codes for the circle from points block
package cfp_pkg;

   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SQ_W         = 2 * DIFF_W + 1;
   localparam int DET_W        = 2 * DIFF_W + 1;
   localparam int ADET_W       = DET_W - 1;
   localparam int NUM_W        = SQ_W + DIFF_W;
   localparam int DEN_W        = ADET_W + 1;
   localparam int QUO_W        = NUM_W;
   localparam int U_LIMIT_LOG  = 40;
   localparam int U_W          = U_LIMIT_LOG + 2;
   localparam int OUT_W        = 32;
   localparam int SUM_W        = U_W + 1;
   localparam int RAD_IN_W     = 2 * OUT_W;
   localparam int REM_W        = OUT_W + 2;
   localparam int ROOT_STEPS   = OUT_W;
   localparam int CFG_W        = 31;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 32;

   localparam logic [1:0] CMD_THREE_POINTS = 2'd0;
   localparam logic [1:0] CMD_CENTER_POINT = 2'd1;
   localparam logic [1:0] CMD_CENTER_SPAN  = 2'd2;
   localparam logic [1:0] CMD_NONE         = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_COLLINEAR_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RADIUS          = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]                 cmd;
      logic signed [COORD_W-1:0]  point_a_x;
      logic signed [COORD_W-1:0]  point_a_y;
      logic signed [COORD_W-1:0]  point_b_x;
      logic signed [COORD_W-1:0]  point_b_y;
      logic signed [COORD_W-1:0]  point_c_x;
      logic signed [COORD_W-1:0]  point_c_y;
      logic                       points_valid;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] ctr_x;
      logic signed [OUT_W-1:0] ctr_y;
      logic [OUT_W-1:0]        radius;
      logic                    circle_valid;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic                      vld;
      logic                      kill;
      logic                      mode0;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [DIFF_W-1:0]  lx;
      logic signed [DIFF_W-1:0]  ly;
      logic                      neg_x;
      logic                      neg_y;
   } div_side_type;

   typedef struct packed {
      div_side_type      side;
      logic [DEN_W-1:0]  den;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [DEN_W-1:0]  rem_x;
      logic [DEN_W-1:0]  rem_y;
      logic [QUO_W-1:0]  quo_x;
      logic [QUO_W-1:0]  quo_y;
   } div_word_type;

   typedef struct packed {
      logic                    vld;
      logic                    kill;
      logic                    mode0;
      logic signed [OUT_W-1:0] cx;
      logic signed [OUT_W-1:0] cy;
      logic                    csat;
      logic                    rad_sat;
   } root_side_type;

   typedef struct packed {
      root_side_type       side;
      logic [RAD_IN_W-1:0] sq;
      logic [REM_W-1:0]    rem;
      logic [OUT_W-1:0]    root;
   } root_word_type;

endpackage

// ===== rtl/cfp_div_cell.sv =====
// one quotient bit of the paired centre offset dividers
module cfp_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cfp_pkg::div_word_type src,
   output cfp_pkg::div_word_type dst
);
   import cfp_pkg::*;

   logic [DEN_W:0] trial_x;
   logic [DEN_W:0] trial_y;
   logic           ge_x;
   logic           ge_y;
   div_word_type   word_in;
   div_word_type   word_ff;

   always_comb begin
      trial_x = {src.rem_x, src.num_x[NUM_W-1]};
      trial_y = {src.rem_y, src.num_y[NUM_W-1]};
      ge_x    = trial_x >= {1'b0, src.den};
      ge_y    = trial_y >= {1'b0, src.den};
      word_in       = src;
      word_in.num_x = {src.num_x[NUM_W-2:0], 1'b0};
      word_in.num_y = {src.num_y[NUM_W-2:0], 1'b0};
      word_in.rem_x = ge_x ? DEN_W'(trial_x - {1'b0, src.den}) : trial_x[DEN_W-1:0];
      word_in.rem_y = ge_y ? DEN_W'(trial_y - {1'b0, src.den}) : trial_y[DEN_W-1:0];
      word_in.quo_x = {src.quo_x[QUO_W-2:0], ge_x};
      word_in.quo_y = {src.quo_y[QUO_W-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.side.vld <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign dst = word_ff;

endmodule

// ===== rtl/cfp_root_cell.sv =====
// one result bit of the radius square root
module cfp_root_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  cfp_pkg::root_word_type src,
   output cfp_pkg::root_word_type dst
);
   import cfp_pkg::*;

   logic [REM_W+1:0] rem4;
   logic [REM_W+1:0] trial;
   logic             ge;
   root_word_type    word_in;
   root_word_type    word_ff;

   always_comb begin
      rem4  = {src.rem, src.sq[RAD_IN_W-1:RAD_IN_W-2]};
      trial = {2'b00, src.root, 2'b01};
      ge    = rem4 >= trial;
      word_in      = src;
      word_in.sq   = {src.sq[RAD_IN_W-3:0], 2'b00};
      word_in.rem  = ge ? REM_W'(rem4 - trial) : rem4[REM_W-1:0];
      word_in.root = {src.root[OUT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.side.vld <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign dst = word_ff;

endmodule

// ===== rtl/circle_from_points.sv =====
// circle from points: top level with front end, divider and root chains
//
// Input words (req_) carry three Q8.8 points, a command and a points valid
// flag; result words (rsp_) carry the centre, radius and two flags. Both use
// valid/ready. Command 0 fits the circle through all three points, 1 uses A
// as centre through B, 2 uses A as centre with radius |C-B|.
// Registers are written on the csr_ port (index 0 collinear threshold,
// index 1 minimum radius) and csr_ready is always high.
// Pipeline: six front end stages, 52 divider cells (one quotient bit each,
// x and y side by side), four stages of clamp, centre and squares, 32
// square root cells (one root bit each) and the output register.
// Throughput: one word per cycle while the skid register is empty; every
// stage moves together.
// When the receiver stalls, the pending result is parked in a skid register
// and the whole pipe holds until it is taken; req_ready drops meanwhile.
// Reset clears the pipe, the skid register and sets both registers to 1.
module circle_from_points (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cfp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cfp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cfp_pkg::*;
   `include "circle_from_points_defines.svh"

   localparam logic [QUO_W-1:0] U_LIMIT = QUO_W'(1) << U_LIMIT_LOG;

   logic en;
   logic [CFG_W-1:0] thr_ff;
   logic [CFG_W-1:0] min_rad_ff;

   // front end
   logic s1_vld_ff, s1_kill_ff, s1_mode0_ff;
   logic signed [COORD_W-1:0] s1_ax_ff, s1_ay_ff;
   logic signed [DIFF_W-1:0]  s1_px_ff, s1_py_ff, s1_qx_ff, s1_qy_ff, s1_lx_ff, s1_ly_ff;

   logic s2_vld_ff, s2_kill_ff, s2_mode0_ff;
   logic signed [COORD_W-1:0] s2_ax_ff, s2_ay_ff;
   logic signed [DIFF_W-1:0]  s2_px_ff, s2_py_ff, s2_qx_ff, s2_qy_ff, s2_lx_ff, s2_ly_ff;
   logic signed [SQ_W-1:0]    s2_pxx_ff, s2_pyy_ff, s2_qxx_ff, s2_qyy_ff;
   logic signed [DET_W-1:0]   s2_d1_ff, s2_d2_ff;

   logic s3_vld_ff, s3_kill_ff, s3_mode0_ff;
   logic signed [COORD_W-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [DIFF_W-1:0]  s3_px_ff, s3_py_ff, s3_qx_ff, s3_qy_ff, s3_lx_ff, s3_ly_ff;
   logic signed [SQ_W-1:0]    s3_b2_ff, s3_c2_ff;
   logic signed [DET_W-1:0]   s3_det_ff;

   logic [ADET_W-1:0] adet_in;
   logic              coll_in;

   logic s4_vld_ff, s4_kill_ff, s4_mode0_ff, s4_dneg_ff;
   logic signed [COORD_W-1:0] s4_ax_ff, s4_ay_ff;
   logic signed [DIFF_W-1:0]  s4_lx_ff, s4_ly_ff;
   logic signed [NUM_W-1:0]   s4_nx1_ff, s4_nx2_ff, s4_ny1_ff, s4_ny2_ff;
   logic [ADET_W-1:0]         s4_adet_ff;

   logic s5_vld_ff, s5_kill_ff, s5_mode0_ff, s5_dneg_ff;
   logic signed [COORD_W-1:0] s5_ax_ff, s5_ay_ff;
   logic signed [DIFF_W-1:0]  s5_lx_ff, s5_ly_ff;
   logic signed [NUM_W-1:0]   s5_nx_ff, s5_ny_ff;
   logic [ADET_W-1:0]         s5_adet_ff;

   logic [NUM_W-1:0] absnx_in, absny_in;
   div_word_type     div_in;
   div_word_type     div_w [QUO_W+1];

   // clamp and centre
   logic [U_W-2:0]          magx_in, magy_in;
   logic signed [U_W-1:0]   smx_in, smy_in, ux_in, uy_in;
   logic s7_vld_ff, s7_kill_ff, s7_mode0_ff;
   logic signed [COORD_W-1:0] s7_ax_ff, s7_ay_ff;
   logic signed [U_W-1:0]     s7_offx_ff, s7_offy_ff, s7_vx_ff, s7_vy_ff;

   logic signed [SUM_W-1:0] sumx_in, sumy_in;
   logic [SUM_W-OUT_W:0]    hix_in, hiy_in;
   logic pox_in, nox_in, poy_in, noy_in;
   logic s8_vld_ff, s8_kill_ff, s8_mode0_ff, s8_csat_ff;
   logic signed [OUT_W-1:0] s8_cx_ff, s8_cy_ff;
   logic [U_W-2:0]          s8_absvx_ff, s8_absvy_ff;

   logic s9_vld_ff, s9_kill_ff, s9_mode0_ff, s9_csat_ff, s9_big_ff;
   logic signed [OUT_W-1:0] s9_cx_ff, s9_cy_ff;
   logic [RAD_IN_W-1:0]     s9_sx_ff, s9_sy_ff;

   logic [RAD_IN_W:0] rsum_in;
   root_word_type     root_in;
   root_word_type     root_w [ROOT_STEPS+1];

   // output
   logic [OUT_W:0]   r33_in;
   logic             rsat_in;
   logic [OUT_W-1:0] rad_in;
   rsp_type          last_in;
   rsp_type          last_ff;
   logic             last_vld_ff;
   rsp_type          skid_ff;
   logic             skid_full_ff;

   assign en        = !skid_full_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= CFG_W'(1);
         min_rad_ff <= CFG_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_COLLINEAR_THRESHOLD: thr_ff     <= csr_data[CFG_W-1:0];
            REG_MIN_RADIUS:          min_rad_ff <= csr_data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: differences
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff   <= req_valid;
         s1_kill_ff  <= !req_data.points_valid || (req_data.cmd == CMD_NONE);
         s1_mode0_ff <= req_data.cmd == CMD_THREE_POINTS;
         s1_ax_ff    <= req_data.point_a_x;
         s1_ay_ff    <= req_data.point_a_y;
         s1_px_ff    <= DIFF_W'(req_data.point_b_x) - DIFF_W'(req_data.point_a_x);
         s1_py_ff    <= DIFF_W'(req_data.point_b_y) - DIFF_W'(req_data.point_a_y);
         s1_qx_ff    <= DIFF_W'(req_data.point_c_x) - DIFF_W'(req_data.point_a_x);
         s1_qy_ff    <= DIFF_W'(req_data.point_c_y) - DIFF_W'(req_data.point_a_y);
         if (req_data.cmd == CMD_CENTER_POINT) begin
            s1_lx_ff <= DIFF_W'(req_data.point_b_x) - DIFF_W'(req_data.point_a_x);
            s1_ly_ff <= DIFF_W'(req_data.point_b_y) - DIFF_W'(req_data.point_a_y);
         end else begin
            s1_lx_ff <= DIFF_W'(req_data.point_c_x) - DIFF_W'(req_data.point_b_x);
            s1_ly_ff <= DIFF_W'(req_data.point_c_y) - DIFF_W'(req_data.point_b_y);
         end
      end
   end

   // stage 2: squares and cross terms
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff   <= s1_vld_ff;
         s2_kill_ff  <= s1_kill_ff;
         s2_mode0_ff <= s1_mode0_ff;
         s2_ax_ff    <= s1_ax_ff;
         s2_ay_ff    <= s1_ay_ff;
         s2_px_ff    <= s1_px_ff;
         s2_py_ff    <= s1_py_ff;
         s2_qx_ff    <= s1_qx_ff;
         s2_qy_ff    <= s1_qy_ff;
         s2_lx_ff    <= s1_lx_ff;
         s2_ly_ff    <= s1_ly_ff;
         s2_pxx_ff   <= SQ_W'(s1_px_ff) * SQ_W'(s1_px_ff);
         s2_pyy_ff   <= SQ_W'(s1_py_ff) * SQ_W'(s1_py_ff);
         s2_qxx_ff   <= SQ_W'(s1_qx_ff) * SQ_W'(s1_qx_ff);
         s2_qyy_ff   <= SQ_W'(s1_qy_ff) * SQ_W'(s1_qy_ff);
         s2_d1_ff    <= DET_W'(s1_px_ff) * DET_W'(s1_qy_ff);
         s2_d2_ff    <= DET_W'(s1_py_ff) * DET_W'(s1_qx_ff);
      end
   end

   // stage 3: squared lengths and determinant
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff   <= s2_vld_ff;
         s3_kill_ff  <= s2_kill_ff;
         s3_mode0_ff <= s2_mode0_ff;
         s3_ax_ff    <= s2_ax_ff;
         s3_ay_ff    <= s2_ay_ff;
         s3_px_ff    <= s2_px_ff;
         s3_py_ff    <= s2_py_ff;
         s3_qx_ff    <= s2_qx_ff;
         s3_qy_ff    <= s2_qy_ff;
         s3_lx_ff    <= s2_lx_ff;
         s3_ly_ff    <= s2_ly_ff;
         s3_b2_ff    <= s2_pxx_ff + s2_pyy_ff;
         s3_c2_ff    <= s2_qxx_ff + s2_qyy_ff;
         s3_det_ff   <= s2_d1_ff - s2_d2_ff;
      end
   end

   always_comb begin
      adet_in = s3_det_ff[DET_W-1] ? ADET_W'(-s3_det_ff) : ADET_W'(s3_det_ff);
      coll_in = (adet_in == '0) || (adet_in < ADET_W'(thr_ff));
   end

   // stage 4: numerator products, collinear check
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff   <= s3_vld_ff;
         s4_kill_ff  <= s3_kill_ff || (s3_mode0_ff && coll_in);
         s4_mode0_ff <= s3_mode0_ff;
         s4_dneg_ff  <= s3_det_ff[DET_W-1];
         s4_ax_ff    <= s3_ax_ff;
         s4_ay_ff    <= s3_ay_ff;
         s4_lx_ff    <= s3_lx_ff;
         s4_ly_ff    <= s3_ly_ff;
         s4_adet_ff  <= adet_in;
         s4_nx1_ff   <= NUM_W'(s3_b2_ff) * NUM_W'(s3_qy_ff);
         s4_nx2_ff   <= NUM_W'(s3_c2_ff) * NUM_W'(s3_py_ff);
         s4_ny1_ff   <= NUM_W'(s3_c2_ff) * NUM_W'(s3_px_ff);
         s4_ny2_ff   <= NUM_W'(s3_b2_ff) * NUM_W'(s3_qx_ff);
      end
   end

   // stage 5: numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff   <= s4_vld_ff;
         s5_kill_ff  <= s4_kill_ff;
         s5_mode0_ff <= s4_mode0_ff;
         s5_dneg_ff  <= s4_dneg_ff;
         s5_ax_ff    <= s4_ax_ff;
         s5_ay_ff    <= s4_ay_ff;
         s5_lx_ff    <= s4_lx_ff;
         s5_ly_ff    <= s4_ly_ff;
         s5_adet_ff  <= s4_adet_ff;
         s5_nx_ff    <= s4_nx1_ff - s4_nx2_ff;
         s5_ny_ff    <= s4_ny1_ff - s4_ny2_ff;
      end
   end

   // stage 6: rounding offset folded into the dividend
   always_comb begin
      absnx_in = s5_nx_ff[NUM_W-1] ? NUM_W'(-s5_nx_ff) : NUM_W'(s5_nx_ff);
      absny_in = s5_ny_ff[NUM_W-1] ? NUM_W'(-s5_ny_ff) : NUM_W'(s5_ny_ff);
      div_in.side.vld   = s5_vld_ff;
      div_in.side.kill  = s5_kill_ff;
      div_in.side.mode0 = s5_mode0_ff;
      div_in.side.ax    = s5_ax_ff;
      div_in.side.ay    = s5_ay_ff;
      div_in.side.lx    = s5_lx_ff;
      div_in.side.ly    = s5_ly_ff;
      div_in.side.neg_x = s5_nx_ff[NUM_W-1] ^ s5_dneg_ff;
      div_in.side.neg_y = s5_ny_ff[NUM_W-1] ^ s5_dneg_ff;
      div_in.den        = {s5_adet_ff, 1'b0};
      div_in.num_x      = absnx_in + NUM_W'(s5_adet_ff);
      div_in.num_y      = absny_in + NUM_W'(s5_adet_ff);
      div_in.rem_x      = '0;
      div_in.rem_y      = '0;
      div_in.quo_x      = '0;
      div_in.quo_y      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_w[0].side.vld <= 1'b0;
      end else if (en) begin
         div_w[0] <= div_in;
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      cfp_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .src   (div_w[i]),
         .dst   (div_w[i+1])
      );
   end

   // stage 7: clamp and sign the offsets, or pass the lengths through
   always_comb begin
      magx_in = (div_w[QUO_W].quo_x > U_LIMIT) ? U_LIMIT[U_W-2:0]
                                              : div_w[QUO_W].quo_x[U_W-2:0];
      magy_in = (div_w[QUO_W].quo_y > U_LIMIT) ? U_LIMIT[U_W-2:0]
                                              : div_w[QUO_W].quo_y[U_W-2:0];
      smx_in  = {1'b0, magx_in};
      smy_in  = {1'b0, magy_in};
      ux_in   = div_w[QUO_W].side.neg_x ? -smx_in : smx_in;
      uy_in   = div_w[QUO_W].side.neg_y ? -smy_in : smy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff   <= div_w[QUO_W].side.vld;
         s7_kill_ff  <= div_w[QUO_W].side.kill;
         s7_mode0_ff <= div_w[QUO_W].side.mode0;
         s7_ax_ff    <= div_w[QUO_W].side.ax;
         s7_ay_ff    <= div_w[QUO_W].side.ay;
         if (div_w[QUO_W].side.mode0) begin
            s7_offx_ff <= ux_in;
            s7_offy_ff <= uy_in;
            s7_vx_ff   <= ux_in;
            s7_vy_ff   <= uy_in;
         end else begin
            s7_offx_ff <= '0;
            s7_offy_ff <= '0;
            s7_vx_ff   <= U_W'(div_w[QUO_W].side.lx);
            s7_vy_ff   <= U_W'(div_w[QUO_W].side.ly);
         end
      end
   end

   // stage 8: centre with saturation, length magnitudes
   always_comb begin
      sumx_in = SUM_W'(s7_ax_ff) + SUM_W'(s7_offx_ff);
      sumy_in = SUM_W'(s7_ay_ff) + SUM_W'(s7_offy_ff);
      hix_in  = sumx_in[SUM_W-1:OUT_W-1];
      hiy_in  = sumy_in[SUM_W-1:OUT_W-1];
      pox_in  = !sumx_in[SUM_W-1] && (|hix_in);
      nox_in  = sumx_in[SUM_W-1] && !(&hix_in);
      poy_in  = !sumy_in[SUM_W-1] && (|hiy_in);
      noy_in  = sumy_in[SUM_W-1] && !(&hiy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff   <= s7_vld_ff;
         s8_kill_ff  <= s7_kill_ff;
         s8_mode0_ff <= s7_mode0_ff;
         s8_csat_ff  <= pox_in || nox_in || poy_in || noy_in;
         s8_cx_ff    <= pox_in ? {1'b0, {(OUT_W-1){1'b1}}} :
                        nox_in ? {1'b1, {(OUT_W-1){1'b0}}} : sumx_in[OUT_W-1:0];
         s8_cy_ff    <= poy_in ? {1'b0, {(OUT_W-1){1'b1}}} :
                        noy_in ? {1'b1, {(OUT_W-1){1'b0}}} : sumy_in[OUT_W-1:0];
         s8_absvx_ff <= s7_vx_ff[U_W-1] ? (U_W-1)'(-s7_vx_ff) : (U_W-1)'(s7_vx_ff);
         s8_absvy_ff <= s7_vy_ff[U_W-1] ? (U_W-1)'(-s7_vy_ff) : (U_W-1)'(s7_vy_ff);
      end
   end

   // stage 9: squared components
   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff   <= s8_vld_ff;
         s9_kill_ff  <= s8_kill_ff;
         s9_mode0_ff <= s8_mode0_ff;
         s9_csat_ff  <= s8_csat_ff;
         s9_cx_ff    <= s8_cx_ff;
         s9_cy_ff    <= s8_cy_ff;
         s9_big_ff   <= (|s8_absvx_ff[U_W-2:OUT_W]) || (|s8_absvy_ff[U_W-2:OUT_W]);
         s9_sx_ff    <= RAD_IN_W'(s8_absvx_ff[OUT_W-1:0]) * RAD_IN_W'(s8_absvx_ff[OUT_W-1:0]);
         s9_sy_ff    <= RAD_IN_W'(s8_absvy_ff[OUT_W-1:0]) * RAD_IN_W'(s8_absvy_ff[OUT_W-1:0]);
      end
   end

   // stage 10: squared length into the root chain
   always_comb begin
      rsum_in = (RAD_IN_W+1)'(s9_sx_ff) + (RAD_IN_W+1)'(s9_sy_ff);
      root_in.side.vld     = s9_vld_ff;
      root_in.side.kill    = s9_kill_ff;
      root_in.side.mode0   = s9_mode0_ff;
      root_in.side.cx      = s9_cx_ff;
      root_in.side.cy      = s9_cy_ff;
      root_in.side.csat    = s9_csat_ff;
      root_in.side.rad_sat = s9_big_ff || rsum_in[RAD_IN_W];
      root_in.sq           = root_in.side.rad_sat ? '0 : rsum_in[RAD_IN_W-1:0];
      root_in.rem          = '0;
      root_in.root         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_w[0].side.vld <= 1'b0;
      end else if (en) begin
         root_w[0] <= root_in;
      end
   end

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      cfp_root_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .src   (root_w[j]),
         .dst   (root_w[j+1])
      );
   end

   // stage 11: round the root, build the word
   always_comb begin
      r33_in  = {1'b0, root_w[ROOT_STEPS].root}
              + (OUT_W+1)'(root_w[ROOT_STEPS].rem > REM_W'(root_w[ROOT_STEPS].root));
      rsat_in = root_w[ROOT_STEPS].side.rad_sat || r33_in[OUT_W];
      rad_in  = rsat_in ? '1 : r33_in[OUT_W-1:0];
      last_in = '0;
      if (!root_w[ROOT_STEPS].side.kill) begin
         last_in.ctr_x        = root_w[ROOT_STEPS].side.cx;
         last_in.ctr_y        = root_w[ROOT_STEPS].side.cy;
         last_in.radius       = rad_in;
         last_in.circle_valid = root_w[ROOT_STEPS].side.mode0
                              || (rad_in > OUT_W'(min_rad_ff));
         last_in.saturated    = root_w[ROOT_STEPS].side.csat || rsat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_vld_ff <= 1'b0;
      end else if (en) begin
         last_ff     <= last_in;
         last_vld_ff <= root_w[ROOT_STEPS].side.vld;
      end
   end

   // skid register parks a word the receiver did not take
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (last_vld_ff && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
      if (!skid_full_ff) begin
         skid_ff <= last_ff;
      end
   end

   assign rsp_valid = skid_full_ff || last_vld_ff;
   assign rsp_data  = skid_full_ff ? skid_ff : last_ff;

   `CFP_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "result word dropped")
   `CFP_ASSERT_NEXT(a_skid_stable, skid_full_ff && !rsp_ready, $stable(rsp_data), "parked word changed")
   `CFP_ASSERT(a_sat_valid, rsp_valid && rsp_data.saturated |-> rsp_data.circle_valid, "saturated word marked invalid")

endmodule

// ===== tb/sv/tb_circle_from_points.sv =====
// testbench for the circle from points block: directed, register, backpressure and random tests
`timescale 1ns / 1ps

module tb_circle_from_points;
   import cfp_pkg::*;

   typedef logic [127:0] wide_t;
   localparam longint U_CLAMP = longint'(1) <<< 40;
   localparam int SETTLE_CYCLES = 120;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   longint  model_threshold = 1;
   longint  model_min_radius = 1;
   rsp_type circles_due[$];
   int      errors = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      burst_left = 0;
   bit      gaps_on = 1'b1;
   bit      stalls_on = 1'b1;
   int      hold_off = 0;

   circle_from_points DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("circle_from_points test failed");
      $finish;
   end

   function automatic logic [32:0] clip32(longint v);
      if (v > 64'sd2147483647) return {1'b1, 32'h7fffffff};
      if (v < -64'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   // rounded length with the clip flag on top
   function automatic logic [32:0] rounded_length(longint dx, longint dy);
      wide_t mx, my, s, rr;
      logic [32:0] r, t;
      mx = dx < 0 ? wide_t'(-dx) : wide_t'(dx);
      my = dy < 0 ? wide_t'(-dy) : wide_t'(dy);
      if (mx > 128'hffffffff || my > 128'hffffffff) return {1'b1, 32'hffffffff};
      s = mx * mx + my * my;
      if (s > 128'hffffffffffffffff) return {1'b1, 32'hffffffff};
      r = '0;
      for (int i = 32; i >= 0; i--) begin
         t = r | (33'd1 << i);
         if (wide_t'(t) * wide_t'(t) <= s) r = t;
      end
      rr = wide_t'(r) * wide_t'(r);
      if (s - rr > wide_t'(r)) r = r + 33'd1;
      if (r > 33'h0ffffffff) return {1'b1, 32'hffffffff};
      return {1'b0, r[31:0]};
   endfunction

   function automatic longint round_half_det(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad) / (2 * ad);
      if (q > U_CLAMP) q = U_CLAMP;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic rsp_type circle_of(req_type w);
      rsp_type o;
      longint ax, ay, bx, by, cx, cy, px, py, qx, qy, b2, c2, det, ux, uy;
      logic [32:0] len, cxs, cys;
      o = '0;
      ux = 0;
      uy = 0;
      if (!w.points_valid || w.cmd == CMD_NONE) return o;
      ax = longint'(w.point_a_x); ay = longint'(w.point_a_y);
      bx = longint'(w.point_b_x); by = longint'(w.point_b_y);
      cx = longint'(w.point_c_x); cy = longint'(w.point_c_y);
      if (w.cmd == CMD_THREE_POINTS) begin
         px = bx - ax; py = by - ay; qx = cx - ax; qy = cy - ay;
         b2 = px * px + py * py;
         c2 = qx * qx + qy * qy;
         det = px * qy - py * qx;
         if (det == 0 || (det < 0 ? -det : det) < model_threshold) return o;
         ux = round_half_det(b2 * qy - c2 * py, det);
         uy = round_half_det(c2 * px - b2 * qx, det);
         len = rounded_length(ux, uy);
         o.circle_valid = 1'b1;
      end else begin
         if (w.cmd == CMD_CENTER_POINT) len = rounded_length(bx - ax, by - ay);
         else len = rounded_length(cx - bx, cy - by);
         o.circle_valid = longint'(len[31:0]) > model_min_radius;
      end
      cxs = clip32(ax + ux);
      cys = clip32(ay + uy);
      o.ctr_x = cxs[31:0];
      o.ctr_y = cys[31:0];
      o.radius = len[31:0];
      o.saturated = len[32] | cxs[32] | cys[32];
      return o;
   endfunction

   // receiver: random stall pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (stalls_on) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (circles_due.size() == 0) begin
            $display("%0t: result word with none expected, actual %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = circles_due.pop_front();
            words_checked++;
            if (rsp_data.ctr_x !== e.ctr_x || rsp_data.ctr_y !== e.ctr_y ||
                rsp_data.radius !== e.radius || rsp_data.circle_valid !== e.circle_valid ||
                rsp_data.saturated !== e.saturated) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic send_word(req_type w);
      int gap;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      circles_due.insert(circles_due.size(), circle_of(w));
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (circles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_COLLINEAR_THRESHOLD) model_threshold = longint'(value[30:0]);
      else if (idx == REG_MIN_RADIUS) model_min_radius = longint'(value[30:0]);
   endtask

   function automatic req_type make_word(logic [1:0] cmd, int ax, int ay, int bx, int by,
                                         int cx, int cy, logic ok);
      req_type w;
      w.cmd = cmd;
      w.point_a_x = ax[15:0]; w.point_a_y = ay[15:0];
      w.point_b_x = bx[15:0]; w.point_b_y = by[15:0];
      w.point_c_x = cx[15:0]; w.point_c_y = cy[15:0];
      w.points_valid = ok;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int span;
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      w = noise[$bits(req_type)-1:0];
      w.cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
      w.points_valid = ($urandom_range(0, 9) != 0);
      // mostly points near each other so that radii stay moderate
      if ($urandom_range(0, 2) != 0) begin
         span = 1 << $urandom_range(2, 14);
         w.point_b_x = w.point_a_x + 16'($urandom_range(0, 2 * span) - span);
         w.point_b_y = w.point_a_y + 16'($urandom_range(0, 2 * span) - span);
         w.point_c_x = w.point_a_x + 16'($urandom_range(0, 2 * span) - span);
         w.point_c_y = w.point_a_y + 16'($urandom_range(0, 2 * span) - span);
      end
      return w;
   endfunction

   task automatic test_directed();
      gaps_on = 1'b0;
      send_word(make_word(CMD_THREE_POINTS, 0, 0, 256, 0, 0, 256, 1));
      send_word(make_word(CMD_THREE_POINTS, -32768, -32768, 32767, -32768, -32768, 32767, 1));
      send_word(make_word(CMD_THREE_POINTS, 32767, 32767, -32768, 32767, 32767, -32768, 1));
      send_word(make_word(CMD_THREE_POINTS, 0, 0, 256, 256, 512, 512, 1));
      send_word(make_word(CMD_THREE_POINTS, 5, 5, 5, 5, 5, 5, 1));
      send_word(make_word(CMD_THREE_POINTS, 0, 0, 32767, 32766, 32766, 32765, 1));
      send_word(make_word(CMD_THREE_POINTS, -32768, 0, 32767, 1, -32767, 0, 1));
      send_word(make_word(CMD_THREE_POINTS, 0, 0, 2, 1, 4, 3, 1));
      send_word(make_word(CMD_THREE_POINTS, 0, 0, 256, 0, 0, 256, 0));
      send_word(make_word(CMD_CENTER_POINT, 0, 0, 0, 0, 0, 0, 1));
      send_word(make_word(CMD_CENTER_POINT, 0, 0, 1, 0, 0, 0, 1));
      send_word(make_word(CMD_CENTER_POINT, 0, 0, 2, 0, 0, 0, 1));
      send_word(make_word(CMD_CENTER_POINT, -32768, -32768, 32767, 32767, 0, 0, 1));
      send_word(make_word(CMD_CENTER_POINT, 32767, -32768, -32768, 32767, 1, 1, 1));
      send_word(make_word(CMD_CENTER_SPAN, 0, 0, 7, 7, 7, 7, 1));
      send_word(make_word(CMD_CENTER_SPAN, 100, -100, -32768, 32767, 32767, -32768, 1));
      send_word(make_word(CMD_CENTER_SPAN, 0, 0, 0, 0, 1, 1, 1));
      send_word(make_word(CMD_CENTER_SPAN, 0, 0, 0, 0, 1, 1, 0));
      send_word(make_word(CMD_NONE, 1, 2, 3, 4, 5, 6, 1));
      send_word(make_word(CMD_NONE, -1, -1, -1, -1, -1, -1, 0));
      drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_registers();
      logic [CSR_DATA_W-1:0] thr_set [4];
      logic [CSR_DATA_W-1:0] rad_set [4];
      thr_set = '{32'd0, 32'h7fffffff, 32'hffffffff, 32'd4096};
      rad_set = '{32'h7fffffff, 32'd0, 32'h80000100, 32'd300};
      for (int k = 0; k < 4; k++) begin
         write_reg(REG_COLLINEAR_THRESHOLD, thr_set[k]);
         write_reg(REG_MIN_RADIUS, rad_set[k]);
         write_reg(CSR_IDX_W'(2 + k), $urandom);
         send_word(make_word(CMD_THREE_POINTS, 0, 0, 2, 1, 4, 3, 1));
         send_word(make_word(CMD_THREE_POINTS, 0, 0, 64, 0, 0, 64, 1));
         send_word(make_word(CMD_CENTER_POINT, 0, 0, 1, 0, 0, 0, 1));
         send_word(make_word(CMD_CENTER_SPAN, 0, 0, 0, 0, 300, 0, 1));
         for (int i = 0; i < 30; i++) send_word(random_word());
         drain();
      end
      write_reg(REG_COLLINEAR_THRESHOLD, 32'd1);
      write_reg(REG_MIN_RADIUS, 32'd1);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 75) gaps_on = 1'b0;
         if (i % 150 == 0) gaps_on = 1'b1;
         stalls_on = (i % 200) < 160;
         send_word(random_word());
      end
      drain();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_off = 400;
      for (int i = 0; i < 150; i++) send_word(random_word());
      drain();
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_backpressure();
      test_random(300);
      $display("covered %0d words: directed cases, register sweeps, random points", words_sent);
      $display("with a long receiver hold-off; %0d results compared", words_checked);
      if (errors == 0 && circles_due.size() == 0) begin
         $display("circle_from_points test passed");
      end else begin
         $display("circle_from_points test failed");
      end
      $finish;
   end

endmodule
